### hdl/assert_macros.svh
// assertion helpers for the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property sampled on the rising edge, off while reset is high
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// same check, also evaluated during reset
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### hdl/ptt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptt_pkg
// constants and fixed point helpers for the preamble threshold tracker
// ----------------------------------------------------------------------------
package ptt_pkg;

  localparam int MAX_SHORT_LENGTH = 64;
  localparam int MAX_REPEATS      = 16;
  localparam int SAMPLE_WIDTH     = 24;
  localparam int HIST_DEPTH       = MAX_SHORT_LENGTH * (MAX_REPEATS - 1) + 1;
  localparam int HIST_AW          = $clog2(HIST_DEPTH);
  localparam int WIDE             = 58;

  localparam int REG_SHORT_LENGTH  = 0;
  localparam int REG_SHORT_REPEATS = 1;
  localparam int REG_LONG_LENGTH   = 2;
  localparam int REG_UPDATE_PERIOD = 3;
  localparam int REG_SHORT_INIT    = 4;
  localparam int REG_LONG_INIT     = 5;

  localparam logic signed [16:0] K_07         = 17'sd45875;
  localparam logic signed [16:0] K_027        = 17'sd17695;
  localparam logic signed [16:0] K_024        = 17'sd15729;
  localparam logic signed [16:0] K_INV_SQRT12 = 17'sd18919;
  localparam logic signed [SAMPLE_WIDTH-1:0] K_03 = SAMPLE_WIDTH'(1229);

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic signed [WIDE-1:0] wide_t;

  function automatic sample_t sat_s(input wide_t x);
    wide_t hi;
    wide_t lo;
    hi = wide_t'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
    lo = -wide_t'(64'sd1 <<< (SAMPLE_WIDTH - 1));
    if (x > hi) return sample_t'(hi);
    if (x < lo) return sample_t'(lo);
    return sample_t'(x);
  endfunction

  // round to nearest of x / 2^16, halves up
  function automatic wide_t round16(input wide_t x);
    wide_t y;
    y = x + wide_t'(32768);
    return y >>> 16;
  endfunction

endpackage

### hdl/ptt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptt_ram
// single port ram with registered read
// ----------------------------------------------------------------------------
module ptt_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 961
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### hdl/preamble_threshold_tracker.sv
`timescale 1ns / 1ps
// sequence: a peak sample reads and sorts the history taps (R = short repeats, one
//   history ram read per tap) and updates the short threshold; every sample is then
//   written to history and the serial period remainder is reckoned, and the long
//   threshold update, from the held peak or average based, runs when it fires
// throughput: one sample at a time; a result held by m_tready stalls the next one
// reset: synchronous; thresholds load their init values, history reads as zero
// ----------------------------------------------------------------------------
// preamble_threshold_tracker
// tracks short and long preamble detection thresholds from correlator values
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module preamble_threshold_tracker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // short_corr, long_corr, moving_average
  input  logic [71:0] s_tdata,
  // long_peak
  input  logic        s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // short_threshold, long_threshold
  output logic [47:0] m_tdata,
  input  logic        wr_en,
  input  logic [2:0]  wr_index,
  input  logic [23:0] wr_data
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_RD   = 4'd1;
  localparam logic [3:0] ST_INS  = 4'd2;
  localparam logic [3:0] ST_MED  = 4'd3;
  localparam logic [3:0] ST_SBL  = 4'd4;
  localparam logic [3:0] ST_HIST = 4'd5;
  localparam logic [3:0] ST_MOD  = 4'd6;
  localparam logic [3:0] ST_CHK  = 4'd7;
  localparam logic [3:0] ST_AV1  = 4'd8;
  localparam logic [3:0] ST_AV2  = 4'd9;
  localparam logic [3:0] ST_AV3  = 4'd10;
  localparam logic [3:0] ST_LM   = 4'd11;
  localparam logic [3:0] ST_LB   = 4'd12;
  localparam logic [3:0] ST_FIN  = 4'd13;

  localparam int AW = ptt_pkg::HIST_AW;
  localparam int NR = ptt_pkg::MAX_REPEATS;
  localparam int SW = ptt_pkg::SAMPLE_WIDTH;
  localparam logic [AW:0] DEPTH_V = (AW+1)'(ptt_pkg::HIST_DEPTH);

  logic [3:0] state;

  // configuration
  logic [6:0]  short_length;
  logic [4:0]  short_repeats;
  logic [15:0] long_length;
  logic [15:0] update_period;

  // tracker state
  ptt_pkg::sample_t sh;
  ptt_pkg::sample_t lg;
  ptt_pkg::sample_t held;
  logic [15:0]      cnt;
  logic [AW-1:0]    pos;
  logic [AW:0]      fill;

  // per sample work registers
  ptt_pkg::sample_t sc;
  ptt_pkg::sample_t avg;
  logic [6:0]       len_c;
  logic [4:0]       rep_c;
  logic [15:0]      per_c;
  logic [4:0]       j;
  logic [AW-1:0]    taddr;
  logic [AW:0]      tap_dist;
  logic             tap_ok;
  ptt_pkg::sample_t srt [NR];
  ptt_pkg::sample_t srt_next [NR];
  logic [16:0]      rem;
  logic [3:0]       bitn;
  logic signed [27:0] q;
  ptt_pkg::wide_t   pa;
  ptt_pkg::wide_t   pb;
  logic             ov;
  logic [47:0]      odata;

  // ram
  logic             ram_we;
  logic [AW-1:0]    ram_addr;
  logic [SW-1:0]    ram_rdata;

  ptt_pkg::sample_t lc_in;
  ptt_pkg::sample_t ins_v;
  ptt_pkg::sample_t med;
  logic [3:0]       med_idx;
  logic [AW:0]      addr_dec;
  logic [16:0]      rem2;
  logic signed [SW:0] lc_bias;
  ptt_pkg::wide_t   pb_bias;

  logic [6:0]  len_w;
  logic [4:0]  rep_w;
  logic [15:0] per_w;

  assign lc_in = ptt_pkg::sample_t'(s_tdata[47:24]);
  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = ov;
  assign m_tdata  = odata;

  assign ram_we   = (state == ST_HIST);
  assign ram_addr = (state == ST_HIST) ? pos : taddr;

  ptt_ram #(.WIDTH(SW), .DEPTH(ptt_pkg::HIST_DEPTH)) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (sc),
    .rdata (ram_rdata)
  );

  always_comb begin
    len_w = (short_length == 7'd0) ? 7'd1 :
            (short_length > 7'(ptt_pkg::MAX_SHORT_LENGTH)) ?
            7'(ptt_pkg::MAX_SHORT_LENGTH) : short_length;
    rep_w = (short_repeats == 5'd0) ? 5'd1 :
            (short_repeats > 5'(NR)) ? 5'(NR) : short_repeats;
    per_w = (update_period == 16'd0) ? 16'd1 : update_period;
  end

  // sorted insertion of one tap, elements at or beyond j are unused
  assign ins_v = tap_ok ? ptt_pkg::sample_t'(ram_rdata) : '0;
  always_comb begin
    logic le [NR];
    for (int i = 0; i < NR; i++) begin
      le[i] = (5'(i) < j) && (srt[i] <= ins_v);
    end
    for (int i = 0; i < NR; i++) begin
      if (le[i]) begin
        srt_next[i] = srt[i];
      end else if (i == 0) begin
        srt_next[i] = ins_v;
      end else if (le[i-1]) begin
        srt_next[i] = ins_v;
      end else begin
        srt_next[i] = srt[i-1];
      end
    end
  end

  assign med_idx = 4'((5'(rep_c) + 5'd1) >> 1) - 4'd1;
  assign med = srt[med_idx];

  // next tap address: one short length further back, wrapping
  assign addr_dec = ({1'b0, taddr} >= (AW+1)'(len_c)) ?
                    ({1'b0, taddr} - (AW+1)'(len_c)) :
                    ({1'b0, taddr} + DEPTH_V - (AW+1)'(len_c));

  assign rem2 = {rem[15:0], cnt[bitn]};
  assign lc_bias = (SW+1)'(lc_in) + ((lc_in < 0) ? (SW+1)'(4095) : '0);
  assign pb_bias = pb + ((pb < 0) ? ptt_pkg::wide_t'((64'sd1 <<< 28) - 1) : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      ov            <= 1'b0;
      short_length  <= 7'd16;
      short_repeats <= 5'd10;
      long_length   <= 16'd64;
      update_period <= 16'd1000;
      sh            <= SW'(2048);
      lg            <= SW'(4096);
      held          <= '0;
      cnt           <= '0;
      pos           <= '0;
      fill          <= '0;
      j             <= '0;
    end else begin
      if (ov && m_tready && (state != ST_FIN)) begin
        ov <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            sc    <= ptt_pkg::sample_t'(s_tdata[23:0]);
            avg   <= ptt_pkg::sample_t'(s_tdata[71:48]);
            len_c <= len_w;
            rep_c <= rep_w;
            per_c <= per_w;
            if (s_tuser) begin
              if (lc_in > held) begin
                held <= ptt_pkg::sample_t'({lc_bias[SW-1:12], 12'd0});
              end
              srt[0]   <= ptt_pkg::sample_t'(s_tdata[23:0]);
              j        <= 5'd1;
              tap_dist <= (AW+1)'(len_w);
              taddr    <= ({1'b0, pos} >= (AW+1)'(len_w)) ?
                          AW'({1'b0, pos} - (AW+1)'(len_w)) :
                          AW'({1'b0, pos} + DEPTH_V - (AW+1)'(len_w));
              state    <= (rep_w > 5'd1) ? ST_RD : ST_MED;
            end else begin
              state <= ST_HIST;
            end
          end
        end
        ST_RD: begin
          // taps older than everything written since reset read as zero
          tap_ok <= (tap_dist <= fill);
          state  <= ST_INS;
        end
        ST_INS: begin
          for (int i = 0; i < NR; i++) begin
            srt[i] <= srt_next[i];
          end
          j        <= j + 5'd1;
          taddr    <= AW'(addr_dec);
          tap_dist <= tap_dist + (AW+1)'(len_c);
          state    <= ((j + 5'd1) < rep_c) ? ST_RD : ST_MED;
        end
        ST_MED: begin
          pa    <= ptt_pkg::wide_t'(sh) * ptt_pkg::wide_t'(ptt_pkg::K_07);
          pb    <= ptt_pkg::wide_t'(med) * ptt_pkg::wide_t'(ptt_pkg::K_027);
          state <= ST_SBL;
        end
        ST_SBL: begin
          sh    <= ptt_pkg::sat_s(ptt_pkg::round16(pa + pb));
          state <= ST_HIST;
        end
        ST_HIST: begin
          pos   <= (pos == AW'(ptt_pkg::HIST_DEPTH - 1)) ? '0 : pos + AW'(1);
          fill  <= (fill == DEPTH_V) ? fill : fill + (AW+1)'(1);
          cnt   <= cnt + 16'd1;
          rem   <= '0;
          bitn  <= 4'd15;
          state <= ST_MOD;
        end
        ST_MOD: begin
          rem  <= (rem2 >= {1'b0, per_c}) ? (rem2 - {1'b0, per_c}) : rem2;
          bitn <= bitn - 4'd1;
          if (bitn == 4'd0) begin
            state <= ST_CHK;
          end
        end
        ST_CHK: begin
          if (rem != {1'b0, long_length}) begin
            state <= ST_FIN;
          end else if (held > 0) begin
            q     <= 28'(held >>> 12);
            state <= ST_LM;
          end else begin
            pa    <= ptt_pkg::wide_t'(avg) *
                     ptt_pkg::wide_t'($signed({1'b0, long_length}));
            state <= ST_AV1;
          end
        end
        ST_AV1: begin
          pb    <= pa * ptt_pkg::wide_t'(ptt_pkg::K_INV_SQRT12);
          state <= ST_AV2;
        end
        ST_AV2: begin
          // truncate toward zero
          q     <= 28'(pb_bias >>> 28);
          pa    <= ptt_pkg::wide_t'(sh) * ptt_pkg::wide_t'(ptt_pkg::K_07);
          state <= ST_AV3;
        end
        ST_AV3: begin
          sh    <= ptt_pkg::sat_s(ptt_pkg::round16(pa) + ptt_pkg::wide_t'(ptt_pkg::K_03));
          state <= ST_LM;
        end
        ST_LM: begin
          pa    <= ptt_pkg::wide_t'(lg) * ptt_pkg::wide_t'(ptt_pkg::K_07);
          pb    <= ptt_pkg::wide_t'(q) * ptt_pkg::wide_t'(ptt_pkg::K_024);
          state <= ST_LB;
        end
        ST_LB: begin
          lg    <= ptt_pkg::sat_s(ptt_pkg::round16(pa + (pb <<< 12)));
          held  <= '0;
          state <= ST_FIN;
        end
        ST_FIN: begin
          if (cnt == per_c) begin
            cnt <= '0;
          end
          if (!ov || m_tready) begin
            ov    <= 1'b1;
            odata <= {lg, sh};
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      if (wr_en) begin
        case (wr_index)
          3'(ptt_pkg::REG_SHORT_LENGTH):  short_length  <= wr_data[6:0];
          3'(ptt_pkg::REG_SHORT_REPEATS): short_repeats <= wr_data[4:0];
          3'(ptt_pkg::REG_LONG_LENGTH):   long_length   <= wr_data[15:0];
          3'(ptt_pkg::REG_UPDATE_PERIOD): update_period <= wr_data[15:0];
          3'(ptt_pkg::REG_SHORT_INIT):    sh            <= wr_data;
          3'(ptt_pkg::REG_LONG_INIT):     lg            <= wr_data;
          default: begin
          end
        endcase
      end
    end
  end

  `ASSERT_CLK(a_accept_busy, (s_tvalid && s_tready) |=> !s_tready, "accepted while busy")
  `ASSERT_CLK(a_ins_after_rd, (state == ST_INS) |-> ($past(state) == ST_RD), "insert without read")
  `ASSERT_CLK(a_fill_max, fill <= DEPTH_V, "fill count beyond history depth")
  `ASSERT_CLK(a_pos_range, pos < AW'(ptt_pkg::HIST_DEPTH), "history pointer out of range")
  `ASSERT_CLK(a_out_hold, (ov && !m_tready) |=> (ov && $stable(odata)), "result dropped")

endmodule

### verif/preamble_threshold_tracker_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// preamble_threshold_tracker_tb
// drives correlator samples through the threshold tracker under several
// settings and idle patterns, predicts both thresholds per sample and
// compares every result transfer in order
// ----------------------------------------------------------------------------
import ptt_pkg::*;

class threshold_scoreboard;
  localparam longint SMAXV = (64'sd1 <<< (SAMPLE_WIDTH - 1)) - 1;
  localparam longint SMINV = -(64'sd1 <<< (SAMPLE_WIDTH - 1));

  bit [6:0]  cfg_len;
  bit [4:0]  cfg_rep;
  bit [15:0] cfg_long_len;
  bit [15:0] cfg_period;
  longint    hist [HIST_DEPTH];
  int        hist_wr;
  longint    peak_held;
  bit [15:0] count;
  longint    sh_thr;
  longint    lg_thr;
  bit [47:0] pending [$];
  int        errors;

  function new();
    cfg_len = 16; cfg_rep = 10; cfg_long_len = 64; cfg_period = 1000;
    foreach (hist[i]) hist[i] = 0;
    hist_wr = 0; peak_held = 0; count = 0;
    sh_thr = 2048; lg_thr = 4096; errors = 0;
  endfunction

  function longint clip(longint x);
    if (x > SMAXV) return SMAXV;
    if (x < SMINV) return SMINV;
    return x;
  endfunction

  // nearest of x / 2^16, halves toward +inf
  function longint rnd16(longint x);
    return (x + 32768) >>> 16;
  endfunction

  function void write_reg(int idx, bit [23:0] v);
    case (idx)
      REG_SHORT_LENGTH:  cfg_len = v[6:0];
      REG_SHORT_REPEATS: cfg_rep = v[4:0];
      REG_LONG_LENGTH:   cfg_long_len = v[15:0];
      REG_UPDATE_PERIOD: cfg_period = v[15:0];
      REG_SHORT_INIT:    sh_thr = longint'(signed'(v));
      REG_LONG_INIT:     lg_thr = longint'(signed'(v));
      default: ;
    endcase
  endfunction

  function void note_sample(bit [71:0] d, bit pk);
    longint sc, lc, avg, v, tmp, prod;
    longint taps [$];
    int len, rep, per, j, k;
    sc  = longint'(signed'(d[23:0]));
    lc  = longint'(signed'(d[47:24]));
    avg = longint'(signed'(d[71:48]));
    len = (cfg_len < 1) ? 1 : (cfg_len > MAX_SHORT_LENGTH) ? MAX_SHORT_LENGTH : cfg_len;
    rep = (cfg_rep < 1) ? 1 : (cfg_rep > MAX_REPEATS) ? MAX_REPEATS : cfg_rep;
    per = (cfg_period < 1) ? 1 : cfg_period;
    if (pk) begin
      if (lc > peak_held) peak_held = (lc / 4096) * 4096;
      taps.push_back(sc);
      for (j = 1; j < rep; j++)
        taps.push_back(hist[(hist_wr + HIST_DEPTH - j * len) % HIST_DEPTH]);
      for (j = 1; j < rep; j++) begin
        v = taps[j];
        k = j;
        while (k > 0 && taps[k-1] > v) begin
          taps[k] = taps[k-1];
          k--;
        end
        taps[k] = v;
      end
      sh_thr = clip(rnd16(sh_thr * 45875 + taps[(rep + 1) / 2 - 1] * 17695));
    end
    hist[hist_wr] = sc;
    hist_wr = (hist_wr + 1) % HIST_DEPTH;
    count = count + 16'd1;
    if ((count % per) == cfg_long_len) begin
      if (peak_held > 0) tmp = peak_held;
      else begin
        prod = avg * longint'(cfg_long_len) * 18919;
        tmp = (prod / (64'sd1 <<< 28)) * 4096;
        sh_thr = clip(rnd16(sh_thr * 45875) + 1229);
      end
      lg_thr = clip(rnd16(lg_thr * 45875 + tmp * 15729));
      peak_held = 0;
    end
    if (count == per) count = 0;
    pending.push_back({lg_thr[23:0], sh_thr[23:0]});
  endfunction

  task report(string what, longint got, longint want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    errors++;
  endtask

  task check_result(bit [47:0] d);
    bit [47:0] e;
    if (pending.size() == 0) begin
      report("unexpected transfer", longint'(d), 0);
      return;
    end
    e = pending.pop_front();
    if (d[23:0] != e[23:0])
      report("short_threshold", longint'(signed'(d[23:0])), longint'(signed'(e[23:0])));
    if (d[47:24] != e[47:24])
      report("long_threshold", longint'(signed'(d[47:24])), longint'(signed'(e[47:24])));
  endtask
endclass

module preamble_threshold_tracker_tb;
  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [71:0] s_tdata = '0;
  logic        s_tuser = 0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [47:0] m_tdata;
  logic        wr_en = 0;
  logic [2:0]  wr_index = '0;
  logic [23:0] wr_data = '0;

  threshold_scoreboard board = new();
  int src_idle_pct = 0;
  int dst_stall_pct = 0;
  int hold_cycles = 0;

  preamble_threshold_tracker DUT (.*);

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  initial begin
    #400_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // result side: ready decided at falling edge, transfer checked at rising
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_result(m_tdata);
  end

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_tready <= 0;
    end else
      m_tready <= ($urandom_range(99) >= dst_stall_pct);
  end

  task automatic write_reg(int idx, bit [23:0] v);
    @(negedge clk);
    wr_en <= 1; wr_index <= idx[2:0]; wr_data <= v;
    @(negedge clk);
    wr_en <= 0;
    board.write_reg(idx, v);
  endtask

  task automatic send_sample(bit [23:0] sc, bit [23:0] lc, bit pk, bit [23:0] avg);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 0;
      @(negedge clk);
    end
    s_tvalid <= 1; s_tdata <= {avg, lc, sc}; s_tuser <= pk;
    do @(posedge clk); while (!s_tready);
    board.note_sample({avg, lc, sc}, pk);
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic rand_sample(int peak_pct);
    bit [23:0] sc, lc, avg;
    case ($urandom_range(3))
      0: sc = 24'($urandom);
      1: sc = 24'h7FFFFF;
      2: sc = 24'h800000;
      default: sc = 24'($urandom_range(16383));
    endcase
    lc  = ($urandom_range(3) == 0) ? 24'h7FFFFF : 24'($urandom);
    avg = ($urandom_range(4) == 0) ? 24'h800000 : 24'($urandom);
    send_sample(sc, lc, $urandom_range(99) < peak_pct, avg);
  endtask

  initial begin
    int n;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    // directed: extremes, peaks on early zero history, short periods
    write_reg(REG_UPDATE_PERIOD, 4);
    write_reg(REG_LONG_LENGTH, 2);
    send_sample(24'h7FFFFF, 24'h7FFFFF, 1, 24'h7FFFFF);
    send_sample(24'h800000, 24'h800000, 1, 24'h800000);
    send_sample(24'h000FFF, 24'hFFF001, 1, 24'h000000);
    send_sample(24'h000000, 24'h000000, 0, 24'h7FFFFF);
    send_sample(24'h123456, 24'h001FFF, 1, 24'h800000);
    send_sample(24'hFFFFFF, 24'hFFFFFF, 0, 24'hFFFFFF);
    for (n = 0; n < 10; n++) rand_sample(50);
    drain();
    write_reg(REG_SHORT_LENGTH, 0);
    write_reg(REG_SHORT_REPEATS, 0);
    write_reg(REG_UPDATE_PERIOD, 0);
    write_reg(REG_LONG_LENGTH, 0);
    write_reg(REG_SHORT_INIT, 24'h7FFFFF);
    write_reg(REG_LONG_INIT, 24'h800000);
    for (n = 0; n < 8; n++) rand_sample(60);
    drain();
    // random phases under each setting and idle pattern
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_reg(REG_SHORT_LENGTH, 64); write_reg(REG_SHORT_REPEATS, 16);
             write_reg(REG_LONG_LENGTH, 3); write_reg(REG_UPDATE_PERIOD, 40); end
        1: begin write_reg(REG_SHORT_LENGTH, 127); write_reg(REG_SHORT_REPEATS, 31);
             write_reg(REG_LONG_LENGTH, 65535); write_reg(REG_UPDATE_PERIOD, 65535); end
        2: begin write_reg(REG_SHORT_LENGTH, 1); write_reg(REG_SHORT_REPEATS, 1);
             write_reg(REG_LONG_LENGTH, 1); write_reg(REG_UPDATE_PERIOD, 2); end
        3: begin write_reg(REG_SHORT_LENGTH, 5); write_reg(REG_SHORT_REPEATS, 7);
             write_reg(REG_LONG_LENGTH, 9); write_reg(REG_UPDATE_PERIOD, 12);
             write_reg(REG_SHORT_INIT, 24'h800000); write_reg(REG_LONG_INIT, 24'h7FFFFF); end
        4: begin write_reg(REG_SHORT_LENGTH, 16); write_reg(REG_SHORT_REPEATS, 10);
             write_reg(REG_LONG_LENGTH, 20); write_reg(REG_UPDATE_PERIOD, 25);
             write_reg(REG_SHORT_INIT, 2048); write_reg(REG_LONG_INIT, 4096); end
        default: begin write_reg(REG_SHORT_LENGTH, 3); write_reg(REG_SHORT_REPEATS, 4);
             write_reg(REG_UPDATE_PERIOD, 7); write_reg(REG_LONG_LENGTH, 6); end
      endcase
      src_idle_pct  = (ph % 4 == 1) ? 76 : (ph % 4 == 3) ? 36 : 0;
      dst_stall_pct = (ph % 4 == 2) ? 76 : (ph % 4 == 3) ? 36 : 0;
      if (ph == 4) hold_cycles = 600;
      for (n = 0; n < 320; n++) rand_sample(ph == 2 ? 80 : 30);
      drain();
    end
    src_idle_pct = 0; dst_stall_pct = 0;
    if (board.errors == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end
endmodule

### preamble_threshold_tracker.f
+incdir+hdl
hdl/ptt_pkg.sv
hdl/ptt_ram.sv
hdl/preamble_threshold_tracker.sv
verif/preamble_threshold_tracker_tb.sv
